FILE: src/shpp_pkg.sv
// Shared types and constants for the sparse histogram peak picker.
`default_nettype none

package shpp_pkg;

    // Result queue: a final item can produce two results in one cycle.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Results written into the queue on one accepted request.
    typedef struct packed {
        logic first;
        logic second;
    } shpp_push_t;

endpackage : shpp_pkg

`default_nettype wire

FILE: src/shpp_decide.sv
// Held-item register, threshold register and the local maximum decision.
`default_nettype none

module shpp_decide
    import shpp_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int AMP_BITS   = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [AMP_BITS-1:0]   cfg_data,
    input  wire logic                  accept,
    input  wire logic [INDEX_BITS-1:0] row_index,
    input  wire logic [AMP_BITS-1:0]   amplitude,
    input  wire logic                  final_item,
    output shpp_push_t                 push,
    output logic [INDEX_BITS-1:0]      r0_row,
    output logic [AMP_BITS-1:0]        r0_amp,
    output logic                       r0_peak,
    output logic                       r0_last,
    output logic [INDEX_BITS-1:0]      r1_row,
    output logic [AMP_BITS-1:0]        r1_amp,
    output logic                       r1_peak
);

    logic [AMP_BITS-1:0]   threshold_reg;
    logic                  held_valid_reg;
    logic [INDEX_BITS-1:0] held_row_reg;
    logic [AMP_BITS-1:0]   held_amp_reg;
    logic                  held_beats_left_reg;

    logic                  held_valid_next;
    logic [INDEX_BITS-1:0] held_row_next;
    logic [AMP_BITS-1:0]   held_amp_next;
    logic                  held_beats_left_next;

    logic                  apart;
    logic                  held_peak;
    logic                  beats_left;
    logic                  new_peak;

    // Adjacency test in one extra bit so held row + 1 cannot wrap.
    assign apart = {1'b0, row_index} > ({1'b0, held_row_reg} + (INDEX_BITS + 1)'(1));

    assign held_peak = (held_amp_reg > threshold_reg) && held_beats_left_reg
                       && (apart || (held_amp_reg >= amplitude));
    assign beats_left = !held_valid_reg || apart || (amplitude >= held_amp_reg);
    assign new_peak   = (amplitude > threshold_reg) && beats_left;

    always_comb
    begin
        push.first  = accept && (held_valid_reg || final_item);
        push.second = accept && held_valid_reg && final_item;

        // First slot carries the held decision when there is one, else the final item.
        if (held_valid_reg)
        begin
            r0_row  = held_row_reg;
            r0_amp  = held_amp_reg;
            r0_peak = held_peak;
            r0_last = 1'b0;
        end
        else
        begin
            r0_row  = row_index;
            r0_amp  = amplitude;
            r0_peak = new_peak;
            r0_last = 1'b1;
        end
        r1_row  = row_index;
        r1_amp  = amplitude;
        r1_peak = new_peak;

        held_valid_next      = held_valid_reg;
        held_row_next        = held_row_reg;
        held_amp_next        = held_amp_reg;
        held_beats_left_next = held_beats_left_reg;
        if (accept)
        begin
            if (final_item)
            begin
                // Empty the holder at the end of a list.
                held_valid_next      = 1'b0;
                held_row_next        = '0;
                held_amp_next        = '0;
                held_beats_left_next = 1'b1;
            end
            else
            begin
                held_valid_next      = 1'b1;
                held_row_next        = row_index;
                held_amp_next        = amplitude;
                held_beats_left_next = beats_left;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg       <= '0;
            held_valid_reg      <= 1'b0;
            held_row_reg        <= '0;
            held_amp_reg        <= '0;
            held_beats_left_reg <= 1'b1;
        end
        else
        begin
            if (cfg_write)
            begin
                threshold_reg <= cfg_data;
            end
            held_valid_reg      <= held_valid_next;
            held_row_reg        <= held_row_next;
            held_amp_reg        <= held_amp_next;
            held_beats_left_reg <= held_beats_left_next;
        end
    end

    a_final_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_item) |=> (!held_valid_reg && held_beats_left_reg))
        else $error("holder not emptied after final item");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !final_item) |=> (held_valid_reg && held_row_reg == $past(row_index)))
        else $error("non-final item not held");

    a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> (held_beats_left_reg && held_row_reg == '0 && held_amp_reg == '0))
        else $error("empty holder carries stale state");

endmodule : shpp_decide

`default_nettype wire

FILE: src/shpp_out_fifo.sv
// Small result queue that takes up to two results per cycle and gives one.
`default_nettype none

module shpp_out_fifo
    import shpp_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int AMP_BITS   = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire shpp_push_t            push,
    input  wire logic [INDEX_BITS-1:0] r0_row,
    input  wire logic [AMP_BITS-1:0]   r0_amp,
    input  wire logic                  r0_peak,
    input  wire logic                  r0_last,
    input  wire logic [INDEX_BITS-1:0] r1_row,
    input  wire logic [AMP_BITS-1:0]   r1_amp,
    input  wire logic                  r1_peak,
    input  wire logic                  pop,
    output logic                       full_for_two,
    output logic                       head_valid,
    output logic [INDEX_BITS-1:0]      head_row,
    output logic [AMP_BITS-1:0]        head_amp,
    output logic                       head_peak,
    output logic                       head_last
);

    logic [INDEX_BITS-1:0] row_mem  [FIFO_DEPTH];
    logic [AMP_BITS-1:0]   amp_mem  [FIFO_DEPTH];
    logic                  peak_mem [FIFO_DEPTH];
    logic                  last_mem [FIFO_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;
    logic [CNT_W-1:0] push_count;
    logic             do_pop;

    // Power-of-two depth: pointers wrap on their own.
    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign push_count   = CNT_W'(push.first) + CNT_W'(push.second);
    assign do_pop       = pop && (count_reg != '0);

    assign full_for_two = count_reg > CNT_W'(FIFO_DEPTH - 2);
    assign head_valid   = count_reg != '0;
    assign head_row     = row_mem[rd_ptr_reg];
    assign head_amp     = amp_mem[rd_ptr_reg];
    assign head_peak    = peak_mem[rd_ptr_reg];
    assign head_last    = last_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count[PTR_W-1:0];
        rd_ptr_next = do_pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_count - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            row_mem[wr_ptr_reg]  <= r0_row;
            amp_mem[wr_ptr_reg]  <= r0_amp;
            peak_mem[wr_ptr_reg] <= r0_peak;
            last_mem[wr_ptr_reg] <= r0_last;
        end
        if (push.second)
        begin
            row_mem[wr_ptr_plus1]  <= r1_row;
            amp_mem[wr_ptr_plus1]  <= r1_amp;
            peak_mem[wr_ptr_plus1] <= r1_peak;
            last_mem[wr_ptr_plus1] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.second |-> push.first)
        else $error("second result pushed without first");

    a_ptr_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_ptr_reg - rd_ptr_reg) == count_reg[PTR_W-1:0])
        else $error("queue pointers disagree with count");

endmodule : shpp_out_fifo

`default_nettype wire

FILE: src/sparse_histogram_peak_picker_top.sv
// Top level of the sparse histogram peak picker.
`default_nettype none

// Takes one (row_index, amplitude, final_item) request per cycle while in_stall
// is low and emits one decision per cycle while out_stall is low, one item late:
// each item's result appears once its right neighbor has arrived, and a final
// item releases two results (held item and itself). Decisions are made in the
// same cycle the request is accepted and land in a 4-entry result queue at the
// accepting edge. in_stall rises while the queue holds three or more results,
// which only happens when the output side stalls; with the output always taking
// results the queue never holds more than two. The threshold write (cfg_data,
// Q16.8) is always ready and takes effect on the next request.
module sparse_histogram_peak_picker_top
    import shpp_pkg::*;
#(
    parameter int INDEX_BITS = 20,
    parameter int AMP_BITS   = 24
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [AMP_BITS-1:0]   cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [INDEX_BITS-1:0] row_index,
    input  wire logic [AMP_BITS-1:0]   amplitude,
    input  wire logic                  final_item,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [INDEX_BITS-1:0]      peak_row,
    output logic [AMP_BITS-1:0]        peak_amplitude,
    output logic                       is_peak,
    output logic                       end_of_list
);

    shpp_push_t            push;
    logic                  accept;
    logic                  full_for_two;
    logic [INDEX_BITS-1:0] r0_row;
    logic [AMP_BITS-1:0]   r0_amp;
    logic                  r0_peak;
    logic                  r0_last;
    logic [INDEX_BITS-1:0] r1_row;
    logic [AMP_BITS-1:0]   r1_amp;
    logic                  r1_peak;

    assign cfg_ready = 1'b1;
    assign in_stall  = full_for_two;
    assign accept    = in_valid && !in_stall;

    shpp_decide #(
        .INDEX_BITS (INDEX_BITS),
        .AMP_BITS   (AMP_BITS)
    ) u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_valid && cfg_ready),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .row_index  (row_index),
        .amplitude  (amplitude),
        .final_item (final_item),
        .push       (push),
        .r0_row     (r0_row),
        .r0_amp     (r0_amp),
        .r0_peak    (r0_peak),
        .r0_last    (r0_last),
        .r1_row     (r1_row),
        .r1_amp     (r1_amp),
        .r1_peak    (r1_peak)
    );

    shpp_out_fifo #(
        .INDEX_BITS (INDEX_BITS),
        .AMP_BITS   (AMP_BITS)
    ) u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .r0_row       (r0_row),
        .r0_amp       (r0_amp),
        .r0_peak      (r0_peak),
        .r0_last      (r0_last),
        .r1_row       (r1_row),
        .r1_amp       (r1_amp),
        .r1_peak      (r1_peak),
        .pop          (!out_stall),
        .full_for_two (full_for_two),
        .head_valid   (out_valid),
        .head_row     (peak_row),
        .head_amp     (peak_amplitude),
        .head_peak    (is_peak),
        .head_last    (end_of_list)
    );

endmodule : sparse_histogram_peak_picker_top

`default_nettype wire

FILE: dv/sparse_histogram_peak_picker_top_tb.sv
// Testbench for the sparse histogram peak picker: directed lists, random lists, backpressure.
`default_nettype none

module sparse_histogram_peak_picker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W = 20;
    localparam int AMP_W = 24;
    localparam logic [AMP_W-1:0] AMP_MAX = {AMP_W{1'b1}};
    localparam logic [IDX_W-1:0] ROW_MAX = {IDX_W{1'b1}};
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [AMP_W-1:0] amp;
        logic             peak;
        logic             last;
    } peak_decision_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [AMP_W-1:0] cfg_data;
    logic             in_valid;
    logic             in_stall;
    logic [IDX_W-1:0] row_index;
    logic [AMP_W-1:0] amplitude;
    logic             final_item;
    logic             out_valid;
    logic             out_stall;
    logic [IDX_W-1:0] peak_row;
    logic [AMP_W-1:0] peak_amplitude;
    logic             is_peak;
    logic             end_of_list;

    // Predictor state: threshold and the item waiting for its right neighbor.
    logic [AMP_W-1:0] threshold_q;
    logic             hold_valid;
    logic [IDX_W-1:0] hold_row;
    logic [AMP_W-1:0] hold_amp;
    logic             hold_beats_left;

    peak_decision_t decision_q[$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_off_cycles;
    int cycle_count;
    int mismatches;
    int requests_seen;
    int decisions_seen;
    int peaks_seen;
    int stall_cycles;
    int threshold_writes;

    sparse_histogram_peak_picker_top #(
        .INDEX_BITS (IDX_W),
        .AMP_BITS   (AMP_W)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .row_index      (row_index),
        .amplitude      (amplitude),
        .final_item     (final_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .peak_row       (peak_row),
        .peak_amplitude (peak_amplitude),
        .is_peak        (is_peak),
        .end_of_list    (end_of_list)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d decisions outstanding",
                     cycle_count, decision_q.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: long hold-off when requested, otherwise random stalls.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Decide the held item and/or the new one, and queue the expected decisions.
    task automatic predict_decisions(input logic [IDX_W-1:0] r, input logic [AMP_W-1:0] a,
                                     input logic f);
        logic apart;
        logic beats_left;
        peak_decision_t d;
        begin
            beats_left = 1'b1;
            if (hold_valid)
            begin
                // Adjacency without wrap: compare one bit wider.
                apart = {1'b0, r} > ({1'b0, hold_row} + 1'b1);
                d.row  = hold_row;
                d.amp  = hold_amp;
                d.peak = (hold_amp > threshold_q) && hold_beats_left && (apart || hold_amp >= a);
                d.last = 1'b0;
                decision_q.push_back(d);
                beats_left = apart || (a >= hold_amp);
            end
            if (f)
            begin
                d.row  = r;
                d.amp  = a;
                d.peak = (a > threshold_q) && beats_left;
                d.last = 1'b1;
                decision_q.push_back(d);
                hold_valid      = 1'b0;
                hold_row        = '0;
                hold_amp        = '0;
                hold_beats_left = 1'b1;
            end
            else
            begin
                hold_valid      = 1'b1;
                hold_row        = r;
                hold_amp        = a;
                hold_beats_left = beats_left;
            end
        end
    endtask

    task automatic check_decision();
        peak_decision_t exp_d;
        begin
            decisions_seen++;
            if (is_peak)
                peaks_seen++;
            if (decision_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] unexpected decision: row %h amp %h peak %b last %b",
                             $realtime, peak_row, peak_amplitude, is_peak, end_of_list);
            end
            else
            begin
                exp_d = decision_q.pop_front();
                if (peak_row !== exp_d.row || peak_amplitude !== exp_d.amp ||
                    is_peak !== exp_d.peak || end_of_list !== exp_d.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("[%0t] decision mismatch: exp row %h amp %h peak %b last %b,",
                                 $realtime, exp_d.row, exp_d.amp, exp_d.peak, exp_d.last);
                        $display("    got row %h amp %h peak %b last %b",
                                 peak_row, peak_amplitude, is_peak, end_of_list);
                    end
                end
            end
        end
    endtask

    // Sample handshakes at the rising edge; results first, then new requests.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                check_decision();
            if (cfg_valid && cfg_ready)
            begin
                threshold_q = cfg_data;
                threshold_writes++;
            end
            if (in_valid && in_stall)
                stall_cycles++;
            if (in_valid && !in_stall)
            begin
                requests_seen++;
                predict_decisions(row_index, amplitude, final_item);
            end
        end
    end

    task automatic send_request(input logic [IDX_W-1:0] r, input logic [AMP_W-1:0] a,
                                input logic f);
        begin
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid   <= 1'b1;
            row_index  <= r;
            amplitude  <= a;
            final_item <= f;
            // Hold the request until it is taken.
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
        end
    endtask

    task automatic release_input();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic wait_idle();
        begin
            while (decision_q.size() != 0 || in_valid)
                @(posedge clk);
            // A lone non-final request yields nothing; give it time to settle.
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_threshold(input logic [AMP_W-1:0] v);
        begin
            wait_idle();
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= v;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    function automatic logic [AMP_W-1:0] pick_amplitude(input logic [AMP_W-1:0] thr,
                                                         input logic [AMP_W-1:0] prev);
        longint v;
        begin
            case ($urandom_range(4))
                0: v = longint'(AMP_W'($urandom));
                1: v = longint'(thr) + longint'($urandom_range(2)) - 1;
                2: v = longint'(prev) + longint'($urandom_range(6)) - 3;
                3: v = longint'($urandom_range(15));
                default: v = longint'(AMP_MAX) - longint'($urandom_range(3));
            endcase
            if (v < 0)
                v = 0;
            if (v > longint'(AMP_MAX))
                v = longint'(AMP_MAX);
            return v[AMP_W-1:0];
        end
    endfunction

    // Lists with adjacent, spaced, equal and descending rows, plus the row extremes.
    task automatic test_directed();
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            send_request(20'd0, AMP_MAX, 1'b1);
            send_request(20'd3, 24'd0, 1'b1);
            send_request(20'd5, 24'd10, 1'b0);
            send_request(20'd6, 24'd20, 1'b0);
            send_request(20'd7, 24'd15, 1'b1);
            send_request(20'd10, 24'd7, 1'b0);
            send_request(20'd11, 24'd7, 1'b1);
            send_request(20'd20, 24'd3, 1'b0);
            send_request(20'd22, 24'd100, 1'b0);
            send_request(20'd30, 24'd50, 1'b1);
            send_request(20'd40, 24'd9, 1'b0);
            send_request(20'd40, 24'd12, 1'b0);
            send_request(20'd35, 24'd5, 1'b1);
            send_request(ROW_MAX - 1'b1, 24'd1, 1'b0);
            send_request(ROW_MAX, AMP_MAX, 1'b1);
            // Row wraps to zero: must still count as adjacent.
            send_request(ROW_MAX, 24'd5, 1'b0);
            send_request(20'd0, 24'd6, 1'b1);
            release_input();
        end
    endtask

    task automatic test_max_threshold();
        begin
            write_threshold(AMP_MAX);
            send_request(20'd1, AMP_MAX, 1'b1);
            send_request(20'd2, AMP_MAX - 1'b1, 1'b0);
            send_request(20'd3, AMP_MAX, 1'b0);
            send_request(20'd9, 24'd0, 1'b1);
            release_input();
        end
    endtask

    task automatic test_random_lists(input int n_items, input int s_idle, input int r_idle,
                                     input logic [AMP_W-1:0] thr);
        int sent;
        int len;
        logic [IDX_W-1:0] r;
        logic [AMP_W-1:0] a;
        begin
            write_threshold(thr);
            send_idle_pct = s_idle;
            recv_idle_pct = r_idle;
            sent = 0;
            a = thr;
            while (sent < n_items)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 6);
                r = ($urandom_range(7) == 0) ? ROW_MAX - IDX_W'($urandom_range(8))
                                             : IDX_W'($urandom);
                for (int k = 0; k < len; k++)
                begin
                    if (k != 0)
                    begin
                        case ($urandom_range(9))
                            0, 1, 2, 3, 4, 5: r = r + 1'b1;
                            6, 7: r = r + 2'd2;
                            8: r = r + IDX_W'($urandom_range(3, 1000));
                            default: r = ($urandom_range(1) == 0) ? r : IDX_W'($urandom);
                        endcase
                    end
                    a = pick_amplitude(thr, a);
                    send_request(r, a, k == len - 1);
                    sent++;
                end
            end
            release_input();
        end
    endtask

    // Hold the output off long enough for the result queue to fill and stall requests.
    task automatic test_backpressure();
        logic [AMP_W-1:0] a;
        begin
            write_threshold(24'h000080);
            send_idle_pct = 0;
            recv_idle_pct = 0;
            a = 24'h000080;
            hold_off_cycles = 80;
            for (int k = 0; k < 40; k++)
            begin
                a = pick_amplitude(24'h000080, a);
                send_request(k[IDX_W-1:0] * 2'd2 + k[1], a, (k % 3) == 2 || k == 39);
            end
            release_input();
        end
    endtask

    initial
    begin
        rst_n           = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        row_index       = '0;
        amplitude       = '0;
        final_item      = 1'b0;
        out_stall       = 1'b0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        cycle_count     = 0;
        mismatches      = 0;
        requests_seen   = 0;
        decisions_seen  = 0;
        peaks_seen      = 0;
        stall_cycles    = 0;
        threshold_writes = 0;
        threshold_q     = '0;
        hold_valid      = 1'b0;
        hold_row        = '0;
        hold_amp        = '0;
        hold_beats_left = 1'b1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_max_threshold();
        test_random_lists(130, 13, 46, AMP_W'($urandom_range(24'h000100, 24'h008000)));
        test_random_lists(130, 46, 13, 24'd0);
        test_random_lists(130, 0, 0, AMP_W'($urandom));
        test_backpressure();

        while (decision_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (decision_q.size() != 0)
        begin
            mismatches += decision_q.size();
            $display("%0d expected decisions never arrived", decision_q.size());
        end

        $display("Run covered %0d requests and %0d decisions (%0d peaks), %0d threshold writes",
                 requests_seen, decisions_seen, peaks_seen, threshold_writes);
        $display("Input stalled for %0d cycles under output backpressure; %0d mismatches",
                 stall_cycles, mismatches);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
